// ===== hw/rtl/pcda_pkg.sv =====
// Shared types, constants and tables of the pixel charge decay accumulator.
// No dependencies; every other file of the block imports this package.
package pcda_pkg;

   localparam int DEF_CHARGE_BITS   = 32;
   localparam int DEF_TIME_BITS     = 32;
   localparam int DEF_EXP_FRAC_BITS = 16;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_ADC_GAIN    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLLECT_EFF = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_SLOPE = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY_BASE  = 8'd3;

   localparam logic [15:0] GAIN_RESET = 16'd16384;

   localparam int INT_STEPS = 5;    // integer quotient bits, since x below 32
   localparam int TERMS     = 13;   // Taylor terms of exp(-frac)
   localparam int TERM_W    = 4;
   localparam int RECIP_W   = 37;
   localparam int RECIP_SH  = 36;
   localparam int ADD_W     = 36;

   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
   localparam logic [63:0] E_INV_Q32 = 64'd1580030169;

   typedef logic [32:0] exp_tbl_type [32];

   // e^-k in Q1.32, built by the same truncating multiplies as the datapath needs.
   function automatic exp_tbl_type build_exp_tbl();
      exp_tbl_type tbl;
      logic [63:0] e;
      e = 64'h1_0000_0000;
      for (int k = 0; k < 32; k++) begin
         tbl[k] = e[32:0];
         e = (e * E_INV_Q32) >> 32;
      end
      return tbl;
   endfunction

   localparam exp_tbl_type EXP_INT_TBL = build_exp_tbl();

   // floor(2^36/n)+1 gives floor(x/n) exactly for x below 2^32 and n up to 13.
   function automatic logic [RECIP_W-1:0] term_recip(input logic [TERM_W-1:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd2:    m = 37'd34359738369;
         4'd3:    m = 37'd22906492246;
         4'd4:    m = 37'd17179869185;
         4'd5:    m = 37'd13743895348;
         4'd6:    m = 37'd11453246123;
         4'd7:    m = 37'd9817068106;
         4'd8:    m = 37'd8589934593;
         4'd9:    m = 37'd7635497416;
         4'd10:   m = 37'd6871947674;
         4'd11:   m = 37'd6247225158;
         4'd12:   m = 37'd5726623062;
         4'd13:   m = 37'd5286113596;
         default: m = 37'd68719476736;
      endcase
      return m;
   endfunction

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECIDE, ST_CLEAR, ST_GAIN, ST_DEP, ST_SLOPE, ST_TAU, ST_CHECK,
      ST_PZERO, ST_DIVINIT, ST_DIV, ST_TINIT, ST_TDIV, ST_TACC, ST_EMUL, ST_FMUL,
      ST_SUM, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_CLEAR, OP_GAIN, OP_DEP, OP_SLOPE, OP_TAU, OP_PZERO,
      OP_DIVINIT, OP_DIVSTEP, OP_TINIT, OP_TDIV, OP_TACC, OP_EMUL, OP_FMUL, OP_SUM
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                load_out;
      logic                int_phase;
      logic [TERM_W-1:0]   term;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic charge_zero;
      logic backward;
      logic skip_decay;
   } status_type;

endpackage

// ===== hw/rtl/pcda_chan_if.sv =====
// Valid/ready channel interfaces of the pixel charge decay accumulator.
// Depends on pcda_pkg for the configuration port widths.
interface pcda_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [31:0]        time_stamp;
   logic [31:0]        deposit;
   logic signed [31:0] noise_sample;
   modport source (output valid, mode, time_stamp, deposit, noise_sample, input ready);
   modport sink (input valid, mode, time_stamp, deposit, noise_sample, output ready);
endinterface

interface pcda_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [33:0] reading;
   logic               time_went_back;
   modport source (output valid, reading, time_went_back, input ready);
   modport sink (input valid, reading, time_went_back, output ready);
endinterface

interface pcda_csr_if import pcda_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pcda_dpath.sv =====
// Datapath: configuration, pixel state, shared multiplier, serial divider, series.
// Depends on pcda_pkg; sequenced by pcda_ctrl through cmd_type commands.
module pcda_dpath import pcda_pkg::*; #(
   parameter int CHARGE_BITS   = DEF_CHARGE_BITS,
   parameter int TIME_BITS     = DEF_TIME_BITS,
   parameter int EXP_FRAC_BITS = DEF_EXP_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   in_mode,
   input  logic [31:0]            in_time_stamp,
   input  logic [31:0]            in_deposit,
   input  logic signed [31:0]     in_noise_sample,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic signed [33:0]     out_reading,
   output logic                   out_time_went_back
);

   localparam int MAX_TC  = (TIME_BITS > CHARGE_BITS) ? TIME_BITS : CHARGE_BITS;
   localparam int MUL_A_W = (MAX_TC > RECIP_W) ? MAX_TC : RECIP_W;
   localparam int MUL_B_W = 33;
   localparam int P_W     = MUL_A_W + MUL_B_W;
   localparam int TAU_W   = 66;
   localparam int REM_W   = 70;
   localparam int Q_W     = INT_STEPS + EXP_FRAC_BITS;
   localparam int SUM_W   = ((CHARGE_BITS > ADD_W) ? CHARGE_BITS : ADD_W) + 1;
   localparam int FAC_W   = EXP_FRAC_BITS + 1;

   logic [15:0]              adc_gain_ff, collect_eff_ff;
   logic signed [23:0]       decay_slope_ff;
   logic signed [31:0]       decay_base_ff;
   logic                     mode_ff;
   logic [TIME_BITS-1:0]     ts_ff, last_time_ff;
   logic [31:0]              dep_ff;
   logic signed [31:0]       noise_ff;
   logic [CHARGE_BITS-1:0]   charge_ff;
   logic [P_W-1:0]           p_ff;
   logic [ADD_W-1:0]         added_ff;
   logic signed [TAU_W-1:0]  tau_ff;
   logic [REM_W-1:0]         rem_ff, dd_ff;
   logic [Q_W-1:0]           q_ff;
   logic signed [34:0]       s_ff;
   logic signed [33:0]       reading_ff;
   logic                     went_back_ff;

   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [TIME_BITS-1:0]     dt;
   logic [23:0]              slope_mag;
   logic [62:0]              prod_sat;
   logic signed [TAU_W-1:0]  prod_s, base_s, tau_in;
   logic [63:0]              tq;
   logic [REM_W-1:0]         num, rem_sub, rem_in, dd_in;
   logic                     rem_ge;
   logic [31:0]              f32, t_new;
   logic [4:0]               ip;
   logic [32:0]              s_clamp;
   logic signed [34:0]       s_in;
   logic [SUM_W-1:0]         charge_sum;
   logic [CHARGE_BITS-1:0]   charge_new;

   assign dt        = ts_ff - last_time_ff;
   assign slope_mag = decay_slope_ff[23] ? (~decay_slope_ff + 24'd1) : decay_slope_ff;
   assign prod_sat  = (p_ff > (P_W'(1) << 62)) ? (63'(1) << 62) : p_ff[62:0];
   assign prod_s    = $signed({3'b000, prod_sat});
   assign base_s    = {{(TAU_W - 40){decay_base_ff[31]}}, decay_base_ff, 8'd0};
   assign tau_in    = decay_slope_ff[23] ? (base_s - prod_s) : (base_s + prod_s);
   assign tq        = tau_ff[63:0];
   assign num       = REM_W'(dt) << 16;

   always_comb begin
      rem_ge  = (rem_ff >= dd_ff);
      rem_sub = rem_ge ? (rem_ff - dd_ff) : rem_ff;
      rem_in  = cmd.int_phase ? rem_sub : (rem_sub << 1);
      dd_in   = cmd.int_phase ? (dd_ff >> 1) : dd_ff;
   end

   assign f32     = {q_ff[EXP_FRAC_BITS-1:0], {(32 - EXP_FRAC_BITS){1'b0}}};
   assign ip      = q_ff[Q_W-1 -: INT_STEPS];
   assign t_new   = p_ff[RECIP_SH +: 32];
   assign s_clamp = s_ff[34] ? 33'd0 : s_ff[32:0];
   assign s_in    = cmd.term[0] ? (s_ff - $signed({3'b000, t_new}))
                                : (s_ff + $signed({3'b000, t_new}));

   always_comb begin
      charge_sum = SUM_W'(p_ff[EXP_FRAC_BITS +: CHARGE_BITS]) + SUM_W'(added_ff);
      if (charge_sum > SUM_W'({CHARGE_BITS{1'b1}})) begin
         charge_new = {CHARGE_BITS{1'b1}};
      end else begin
         charge_new = charge_sum[CHARGE_BITS-1:0];
      end
   end

   // Operand selection of the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_GAIN: begin
            mul_a = MUL_A_W'(adc_gain_ff);
            mul_b = MUL_B_W'(collect_eff_ff);
         end
         OP_DEP: begin
            mul_a = MUL_A_W'(dep_ff);
            mul_b = MUL_B_W'(p_ff[31:0]);
         end
         OP_SLOPE: begin
            mul_a = MUL_A_W'(dt);
            mul_b = MUL_B_W'(slope_mag);
         end
         OP_TINIT: begin
            mul_a = MUL_A_W'(ONE_Q32);
            mul_b = MUL_B_W'(f32);
         end
         OP_TDIV: begin
            mul_a = MUL_A_W'(term_recip(cmd.term));
            mul_b = MUL_B_W'(p_ff[63:32]);
         end
         OP_TACC: begin
            mul_a = MUL_A_W'(t_new);
            mul_b = MUL_B_W'(f32);
         end
         OP_EMUL: begin
            mul_a = MUL_A_W'(s_clamp);
            mul_b = EXP_INT_TBL[ip];
         end
         OP_FMUL: begin
            mul_a = MUL_A_W'(charge_ff);
            mul_b = MUL_B_W'(p_ff[(64 - EXP_FRAC_BITS) +: FAC_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_gain_ff    <= GAIN_RESET;
         collect_eff_ff <= GAIN_RESET;
         decay_slope_ff <= '0;
         decay_base_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ADC_GAIN:    adc_gain_ff    <= csr_data[15:0];
            REG_COLLECT_EFF: collect_eff_ff <= csr_data[15:0];
            REG_DECAY_SLOPE: decay_slope_ff <= $signed(csr_data[23:0]);
            REG_DECAY_BASE:  decay_base_ff  <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_ff    <= '0;
         last_time_ff <= '0;
      end else if (cmd.op == OP_CLEAR) begin
         charge_ff    <= '0;
         last_time_ff <= '0;
      end else if (cmd.op == OP_SUM) begin
         charge_ff    <= charge_new;
         last_time_ff <= ts_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         mode_ff  <= in_mode;
         ts_ff    <= TIME_BITS'(in_time_stamp);
         dep_ff   <= in_deposit;
         noise_ff <= in_noise_sample;
      end
      case (cmd.op)
         OP_GAIN, OP_DEP, OP_TINIT, OP_TDIV, OP_TACC, OP_EMUL, OP_FMUL: begin
            p_ff <= mul_a * mul_b;
         end
         OP_SLOPE: begin
            added_ff <= p_ff[28 +: ADD_W];
            p_ff     <= mul_a * mul_b;
         end
         OP_TAU: tau_ff <= tau_in;
         OP_PZERO: p_ff <= '0;
         OP_DIVINIT: begin
            rem_ff <= num;
            dd_ff  <= REM_W'(tq) << (INT_STEPS - 1);
            q_ff   <= '0;
         end
         OP_DIVSTEP: begin
            rem_ff <= rem_in;
            dd_ff  <= dd_in;
            q_ff   <= {q_ff[Q_W-2:0], rem_ge};
         end
         default: ;
      endcase
      if (cmd.op == OP_TINIT) begin
         s_ff <= $signed({2'b00, ONE_Q32});
      end else if (cmd.op == OP_TACC) begin
         s_ff <= s_in;
      end
      if (cmd.load_out) begin
         reading_ff   <= $signed(34'(charge_ff)) + 34'(noise_ff);
         went_back_ff <= status.backward;
      end
   end

   always_comb begin
      status.is_clear    = mode_ff;
      status.charge_zero = (charge_ff == '0);
      status.backward    = (charge_ff != '0) && (ts_ff < last_time_ff);
      status.skip_decay  = tau_ff[TAU_W-1] || (tau_ff == '0) ||
                           (num >= (REM_W'(tq) << INT_STEPS));
   end

   assign out_reading        = reading_ff;
   assign out_time_went_back = went_back_ff;

   // A refused event must not touch the pixel state while its result is formed.
   a_back_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && status.backward) |=> $stable(charge_ff) && $stable(last_time_ff))
      else $error("backward event changed the pixel state");

   // The divider only runs on a positive time constant.
   a_div_tau_pos: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIVSTEP) |-> !tau_ff[TAU_W-1] && (tau_ff != '0))
      else $error("divider running on a non-positive time constant");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_CLEAR) |=> (charge_ff == '0) && (last_time_ff == '0))
      else $error("clear left charge or time behind");

endmodule

// ===== hw/rtl/pcda_ctrl.sv =====
// Sequencer of the pixel charge decay accumulator: handshakes and datapath commands.
// Depends on pcda_pkg; drives pcda_dpath.
module pcda_ctrl import pcda_pkg::*; #(
   parameter int EXP_FRAC_BITS = DEF_EXP_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int Q_W   = INT_STEPS + EXP_FRAC_BITS;
   localparam int CNT_W = $clog2(Q_W);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (status.is_clear) begin
               state_in = ST_CLEAR;
            end else if (status.backward) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_GAIN;
            end
         end
         ST_CLEAR:   state_in = ST_OUT;
         ST_GAIN:    state_in = ST_DEP;
         ST_DEP:     state_in = ST_SLOPE;
         ST_SLOPE:   state_in = status.charge_zero ? ST_PZERO : ST_TAU;
         ST_TAU:     state_in = ST_CHECK;
         ST_CHECK:   state_in = status.skip_decay ? ST_PZERO : ST_DIVINIT;
         ST_PZERO:   state_in = ST_SUM;
         ST_DIVINIT: state_in = ST_DIV;
         ST_DIV:     if (cnt_ff == CNT_W'(Q_W - 1)) state_in = ST_TINIT;
         ST_TINIT:   state_in = ST_TDIV;
         ST_TDIV:    state_in = ST_TACC;
         ST_TACC:    state_in = (cnt_ff == CNT_W'(TERMS)) ? ST_EMUL : ST_TDIV;
         ST_EMUL:    state_in = ST_FMUL;
         ST_FMUL:    state_in = ST_SUM;
         ST_SUM:     state_in = ST_OUT;
         ST_OUT:     if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op        = OP_NONE;
      cmd.load_out  = 1'b0;
      cmd.int_phase = (cnt_ff < CNT_W'(INT_STEPS - 1));
      cmd.term      = cnt_ff[TERM_W-1:0];
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_CLEAR:   cmd.op = OP_CLEAR;
         ST_GAIN:    cmd.op = OP_GAIN;
         ST_DEP:     cmd.op = OP_DEP;
         ST_SLOPE:   cmd.op = OP_SLOPE;
         ST_TAU:     cmd.op = OP_TAU;
         ST_PZERO:   cmd.op = OP_PZERO;
         ST_DIVINIT: cmd.op = OP_DIVINIT;
         ST_DIV:     cmd.op = OP_DIVSTEP;
         ST_TINIT:   cmd.op = OP_TINIT;
         ST_TDIV:    cmd.op = OP_TDIV;
         ST_TACC:    cmd.op = OP_TACC;
         ST_EMUL:    cmd.op = OP_EMUL;
         ST_FMUL:    cmd.op = OP_FMUL;
         ST_SUM:     cmd.op = OP_SUM;
         ST_OUT:     cmd.load_out = out_free;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // The counter steps the divider from zero and the series terms from one.
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_DIVINIT) begin
         cnt_in = '0;
      end else if (state_ff == ST_TINIT) begin
         cnt_in = CNT_W'(1);
      end else if (state_ff == ST_DIV || state_ff == ST_TACC) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DECIDE))
      else $error("accepted word did not start an event");

   a_out_loads_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result load did not raise the output word");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_W'(Q_W - 1)))
      else $error("divider step count out of range");

   a_series_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TDIV) |-> (cnt_ff >= CNT_W'(1)) && (cnt_ff <= CNT_W'(TERMS)))
      else $error("series term index out of range");

endmodule

// ===== hw/rtl/pixel_charge_decay_accumulator.sv =====
// From input accept, a backward-time event goes straight to the output, a clear takes one
// clear step first, an empty pixel or a skipped decay bypass the divider, and a full decay
// runs the divider and the series. A new word is taken only once the result is loaded.
// The serial divider (one quotient bit a cycle) and the 13-term series on the shared
// multiplier do most of the work of a full decay. Synchronous active-high reset clears
// charge, time and the output valid; gains reset to 1.0, slope and base to zero.
module pixel_charge_decay_accumulator import pcda_pkg::*; #(
   parameter int CHARGE_BITS   = DEF_CHARGE_BITS,
   parameter int TIME_BITS     = DEF_TIME_BITS,
   parameter int EXP_FRAC_BITS = DEF_EXP_FRAC_BITS
) (
   input logic    clock,
   input logic    reset,
   pcda_req_if.sink   req_chan,
   pcda_rsp_if.source rsp_chan,
   pcda_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;

   assign csr_chan.ready = 1'b1;

   pcda_ctrl #(
      .EXP_FRAC_BITS (EXP_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcda_dpath #(
      .CHARGE_BITS   (CHARGE_BITS),
      .TIME_BITS     (TIME_BITS),
      .EXP_FRAC_BITS (EXP_FRAC_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .in_mode            (req_chan.mode),
      .in_time_stamp      (req_chan.time_stamp),
      .in_deposit         (req_chan.deposit),
      .in_noise_sample    (req_chan.noise_sample),
      .csr_write          (csr_chan.valid),
      .csr_index          (csr_chan.index),
      .csr_data           (csr_chan.data),
      .out_reading        (rsp_chan.reading),
      .out_time_went_back (rsp_chan.time_went_back)
   );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the pixel charge decay accumulator.
// Depends on pcda_pkg, the channel interfaces in pcda_chan_if.sv and the block's RTL.
`timescale 1ns / 100ps

module testbench;
   import pcda_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 8'd9;
   localparam int MODE_DEPOSIT = 0;
   localparam int MODE_CLEAR   = 1;
   localparam int DRAIN_CYCLES = 64;
   localparam int IDLE_LIMIT   = 5000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 130;

   typedef struct {
      logic        mode;
      logic [31:0] time_stamp;
      logic [31:0] deposit;
      logic [31:0] noise;
      bit          typed;
      logic [33:0] reading;
      logic        went_back;
   } event_row_type;

   typedef struct {
      logic [33:0] reading;
      logic        went_back;
   } reading_type;

   logic clock;
   logic reset;

   pcda_req_if req_bus ();
   pcda_rsp_if rsp_bus ();
   pcda_csr_if csr_bus ();

   pixel_charge_decay_accumulator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copy of the pixel state and its registers.
   logic [63:0]        charge_q;
   logic [63:0]        last_time_q;
   logic [63:0]        adc_gain_q;
   logic [63:0]        collect_eff_q;
   logic signed [63:0] slope_q;
   logic signed [63:0] base_q;

   reading_type pending_readings[$];
   int          mismatches;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] decay_charge(logic [63:0] chg, logic [63:0] dt);
      logic [63:0]        sp, prod, tq, num, ip, r, frac, f32, t, e;
      logic signed [63:0] tau, s;
      logic [127:0]       wide;
      sp = (slope_q < 0) ? $unsigned(-slope_q) : $unsigned(slope_q);
      if (sp != 0 && dt > (64'd1 << 62) / sp) prod = 64'd1 << 62;
      else prod = sp * dt;
      tau = (slope_q < 0) ? -$signed(prod) : $signed(prod);
      tau = tau + base_q * 256;
      if (tau <= 0) return 64'd0;
      tq = $unsigned(tau);
      num = dt << 16;
      ip = num / tq;
      r = num % tq;
      if (ip >= 32) return 64'd0;
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= tq) begin
            r = r - tq;
            frac = frac | 64'd1;
         end
      end
      // Alternating series for exp(-frac), each term truncated.
      f32 = frac << 16;
      s = 64'sd1 << 32;
      t = 64'd1 << 32;
      for (int n = 1; n <= 13; n++) begin
         t = ((t * f32) >> 32) / n;
         if (n % 2 == 1) s = s - $signed(t);
         else s = s + $signed(t);
      end
      if (s < 0) s = 0;
      e = 64'd1 << 32;
      for (int i = 0; i < ip; i++) e = (e * E_INV_Q32) >> 32;
      wide = {64'd0, $unsigned(s)} * {64'd0, e};
      e = wide[95:32] >> 16;
      wide = {64'd0, chg} * {64'd0, e};
      return wide[79:16];
   endfunction

   function automatic reading_type apply_event(logic mode, logic [31:0] ts, logic [31:0] dep,
                                               logic [31:0] noise);
      reading_type res;
      logic [63:0] chg, added, ts64, noise64;
      ts64 = {32'd0, ts};
      noise64 = {{32{noise[31]}}, noise};
      chg = charge_q;
      res.went_back = 1'b0;
      if (mode == MODE_CLEAR) begin
         charge_q = 0;
         last_time_q = 0;
      end else if (chg > 0 && ts64 < last_time_q) begin
         res.went_back = 1'b1;
      end else begin
         if (chg > 0) chg = decay_charge(chg, ts64 - last_time_q);
         added = ({32'd0, dep} * (adc_gain_q * collect_eff_q)) >> 28;
         chg = chg + added;
         if (chg > 64'hFFFF_FFFF) chg = 64'hFFFF_FFFF;
         charge_q = chg;
         last_time_q = ts64;
      end
      res.reading = charge_q[33:0] + noise64[33:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s is %0h, should be %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (index)
         REG_ADC_GAIN:    adc_gain_q = {48'd0, data[15:0]};
         REG_COLLECT_EFF: collect_eff_q = {48'd0, data[15:0]};
         REG_DECAY_SLOPE: slope_q = {{40{data[23]}}, data[23:0]};
         REG_DECAY_BASE:  base_q = {{32{data[31]}}, data};
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_event(event_row_type row);
      int          gap;
      reading_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= row.mode;
      req_bus.time_stamp   <= row.time_stamp;
      req_bus.deposit      <= row.deposit;
      req_bus.noise_sample <= row.noise;
      do @(posedge clock); while (!req_bus.ready);
      res = apply_event(row.mode, row.time_stamp, row.deposit, row.noise);
      if (row.typed) begin
         res.reading = row.reading;
         res.went_back = row.went_back;
      end
      pending_readings.push_back(res);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_readings.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic event_row_type random_event();
      event_row_type row;
      int            r;
      row.typed = 0;
      row.reading = '0;
      row.went_back = 1'b0;
      row.mode = MODE_DEPOSIT;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         row.mode = MODE_CLEAR;
         row.time_stamp = $urandom;
      end else if (r < 14) begin
         row.time_stamp = last_time_q[31:0] - $urandom_range(1, 5000);
      end else if (r < 70) begin
         row.time_stamp = last_time_q[31:0] + $urandom_range(0, 4000);
      end else if (r < 90) begin
         row.time_stamp = last_time_q[31:0] + $urandom_range(0, 1 << 20);
      end else begin
         row.time_stamp = $urandom;
      end
      r = $urandom_range(0, 99);
      if (r < 50) row.deposit = $urandom_range(0, 1 << 20);
      else if (r < 90) row.deposit = $urandom;
      else if (r < 95) row.deposit = 32'd0;
      else row.deposit = 32'hFFFF_FFFF;
      row.noise = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
      return row;
   endfunction

   task automatic configure_phase(int phase);
      logic [31:0] gain, eff, slope, base;
      case (phase)
         0: begin
            gain = 32'd65535; eff = 32'd65535; slope = 32'h007F_FFFF; base = 32'h7FFF_FFFF;
         end
         1: begin
            gain = 32'd0; eff = 32'd0; slope = 32'h0080_0000; base = 32'h8000_0000;
         end
         2: begin
            gain = GAIN_RESET; eff = GAIN_RESET; slope = 32'd0;
            base = $urandom_range(256, 1 << 20);
         end
         default: begin
            gain = $urandom_range(8000, 40000);
            eff = $urandom_range(0, 65535);
            slope = $urandom_range(0, 200000) - 50000;
            base = ($urandom_range(0, 7) == 0) ? -$urandom_range(0, 1 << 20)
                                               : $urandom_range(0, 1 << 20);
         end
      endcase
      write_reg(REG_ADC_GAIN, gain);
      write_reg(REG_COLLECT_EFF, eff);
      write_reg(REG_DECAY_SLOPE, slope);
      write_reg(REG_DECAY_BASE, base);
      // An unknown index must leave every register alone.
      if (phase == 3) write_reg(REG_UNUSED, $urandom);
   endtask

   // Response side: ready comes and goes in stretches.
   initial begin
      int n;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("outstanding word count", 64'd0, 64'd1);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_bus.reading !== want.reading)
               report_mismatch("reading", rsp_bus.reading, want.reading);
            if (rsp_bus.time_went_back !== want.went_back)
               report_mismatch("time_went_back", rsp_bus.time_went_back, want.went_back);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Directed events at reset settings: tau is zero, so any stored charge empties.
      event_row_type directed[] = '{
         '{MODE_CLEAR, 32'd7, 32'd9, 32'd0, 1, 34'd0, 1'b0},
         '{MODE_DEPOSIT, 32'd100, 32'h0001_0000, 32'd0, 1, 34'h0_0001_0000, 1'b0},
         '{MODE_DEPOSIT, 32'd50, 32'd123, 32'd5, 1, 34'h0_0001_0005, 1'b1},
         '{MODE_DEPOSIT, 32'd200, 32'd0, 32'd0, 1, 34'd0, 1'b0},
         '{MODE_DEPOSIT, 32'd300, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 34'h1_7FFF_FFFE, 1'b0},
         '{MODE_DEPOSIT, 32'd0, 32'd1, 32'h8000_0000, 1, 34'h0_7FFF_FFFF, 1'b1},
         '{MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 34'h3_FFFF_FFFF, 1'b0},
         '{MODE_DEPOSIT, 32'd1000, 32'd0, 32'd3, 0, 34'd0, 1'b0},
         '{MODE_DEPOSIT, 32'd10, 32'd5, 32'h1234_5678, 0, 34'd0, 1'b0},
         '{MODE_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0, 34'd0, 1'b0},
         '{MODE_DEPOSIT, 32'hFFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA, 0, 34'd0, 1'b0},
         '{MODE_CLEAR, 32'd0, 32'd0, 32'h8000_0000, 1, 34'h3_8000_0000, 1'b0}
      };
      reset = 1'b1;
      mismatches = 0;
      idle_cycles = 0;
      req_bus.valid = 1'b0;
      req_bus.mode = 1'b0;
      req_bus.time_stamp = '0;
      req_bus.deposit = '0;
      req_bus.noise_sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      charge_q = 0;
      last_time_q = 0;
      adc_gain_q = GAIN_RESET;
      collect_eff_q = GAIN_RESET;
      slope_q = 0;
      base_q = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_event(directed[i]);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         configure_phase(phase);
         for (int k = 0; k < PHASE_ITEMS; k++) send_event(random_event());
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== pixel_charge_decay_accumulator.f =====
hw/rtl/pcda_pkg.sv
hw/rtl/pcda_chan_if.sv
hw/rtl/pcda_dpath.sv
hw/rtl/pcda_ctrl.sv
hw/rtl/pixel_charge_decay_accumulator.sv
test/testbench.sv
